// File: src/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
// No dependencies; every other file imports this package.
`default_nettype none

package bgc_pkg;

  localparam int TimerBitsDefault = 16;
  localparam int TimeW            = 16;
  localparam int AwakeW           = 17;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 16;
  localparam int AwakeExtra       = 100;

  typedef enum logic [1:0] {
    ST_PRESSED  = 2'd0,
    ST_RELEASED = 2'd1,
    ST_FALL     = 2'd2,
    ST_RISE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    G_NONE         = 3'd0,
    G_SHORT        = 3'd1,
    G_LONG         = 3'd2,
    G_LONG_REL     = 3'd3,
    G_DBL_LONG     = 3'd4,
    G_DBL_LONG_REL = 3'd5
  } gesture_t;

  typedef enum logic [1:0] {
    LED_NONE    = 2'd0,
    LED_STOP    = 2'd1,
    LED_SLOW    = 2'd2,
    LED_FAST    = 2'd3
  } led_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE       = 2'd0,
    REG_LONG_TIME  = 2'd1,
    REG_DBL_TIME   = 2'd2,
    REG_RST_DIS    = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] MODE_OFF        = 2'd0;
  localparam logic [1:0] MODE_PAIR_SHORT = 2'd1;
  localparam logic [1:0] MODE_PAIR_LONG  = 2'd2;

  localparam logic [TimeW-1:0] LongTimeReset = 16'd5000;
  localparam logic [TimeW-1:0] DblTimeReset  = 16'd2000;

  typedef struct packed {
    logic [1:0]       button_mode;
    logic [TimeW-1:0] long_time_ms;
    logic [TimeW-1:0] double_timeout_ms;
    logic             local_reset_disable;
  } cfg_t;

  typedef struct packed {
    gesture_t          gesture;
    led_t              led_command;
    logic              send_pairing;
    logic              factory_reset;
    logic [AwakeW-1:0] stay_awake_ms;
  } result_t;

endpackage

`default_nettype wire

// File: src/bgc_if.sv
// Valid/ready channel interfaces for button items and gesture results.
// Depends on bgc_pkg for field widths.
`default_nettype none

interface bgc_in_if import bgc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] button_status;
  logic       tick;

  modport source (output valid, button_status, tick, input ready);
  modport sink   (input valid, button_status, tick, output ready);
endinterface

interface bgc_out_if import bgc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        gesture;
  logic [1:0]        led_command;
  logic              send_pairing;
  logic              factory_reset;
  logic [AwakeW-1:0] stay_awake_ms;

  modport source (output valid, gesture, led_command, send_pairing, factory_reset,
                  stay_awake_ms, input ready);
  modport sink   (input valid, gesture, led_command, send_pairing, factory_reset,
                  stay_awake_ms, output ready);
endinterface

`default_nettype wire

// File: src/bgc_cfg.sv
// Configuration register file for the gesture classifier.
// Depends on bgc_pkg.
`default_nettype none

module bgc_cfg import bgc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_mode         <= MODE_OFF;
      cfg.long_time_ms        <= LongTimeReset;
      cfg.double_timeout_ms   <= DblTimeReset;
      cfg.local_reset_disable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_MODE:      cfg.button_mode         <= cfg_data[1:0];
        REG_LONG_TIME: cfg.long_time_ms        <= cfg_data[TimeW-1:0];
        REG_DBL_TIME:  cfg.double_timeout_ms   <= cfg_data[TimeW-1:0];
        REG_RST_DIS:   cfg.local_reset_disable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/bgc_core.sv
// Gesture state (flags, countdown timer) and combinational classification.
// Depends on bgc_pkg.
`default_nettype none

module bgc_core import bgc_pkg::*; #(
  parameter int TIMER_BITS = TimerBitsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [1:0] button_status,
  input  wire logic       tick,
  input  wire cfg_t       cfg,
  output result_t         res
);

  localparam int CmpW = (TIMER_BITS > TimeW) ? TIMER_BITS : TimeW;
  localparam logic [CmpW-1:0] TimerMax = CmpW'({TIMER_BITS{1'b1}});

  logic                  armed, was_long, double_pending;
  logic                  armed_next, was_long_next, double_pending_next;
  logic [TIMER_BITS-1:0] timer_remaining, timer_remaining_next;

  gesture_t          gest;
  logic [AwakeW-1:0] awake;
  led_t              led;
  logic              pair, freset;
  status_t           st;

  // Saturate a requested time to what the timer holds.
  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [TimeW-1:0] ms);
    logic [CmpW-1:0] ext;
    ext = CmpW'(ms);
    return (ext > TimerMax) ? TIMER_BITS'(TimerMax) : TIMER_BITS'(ext);
  endfunction

  assign st = status_t'(button_status);

  always_comb begin
    armed_next          = armed;
    was_long_next       = was_long;
    double_pending_next = double_pending;
    timer_remaining_next = timer_remaining;
    gest                = G_NONE;
    awake               = '0;

    if (tick && timer_remaining != '0)
      timer_remaining_next = timer_remaining - 1'b1;

    if (cfg.button_mode != MODE_OFF) begin
      if (st == ST_FALL) begin
        awake                = AwakeW'(cfg.long_time_ms) + AwakeW'(AwakeExtra);
        timer_remaining_next = sat_load(cfg.long_time_ms);
        armed_next           = 1'b1;
      end
      if (armed_next) begin
        if (st == ST_RISE) begin
          awake                = AwakeW'(cfg.double_timeout_ms) + AwakeW'(AwakeExtra);
          timer_remaining_next = sat_load(cfg.double_timeout_ms);
          if (was_long && !double_pending) begin
            double_pending_next = 1'b1;
            was_long_next       = 1'b0;
            gest                = G_LONG_REL;
          end else if (was_long) begin
            gest = G_DBL_LONG_REL;
          end else begin
            gest = G_SHORT;
          end
        end
        if (timer_remaining_next == '0) begin
          if (st == ST_PRESSED) begin
            awake                = AwakeW'(cfg.long_time_ms) + AwakeW'(AwakeExtra);
            timer_remaining_next = sat_load(cfg.long_time_ms);
            if (!was_long) begin
              was_long_next = 1'b1;
              gest          = double_pending ? G_DBL_LONG : G_LONG;
            end
          end else if (st == ST_RELEASED) begin
            armed_next          = 1'b0;
            was_long_next       = 1'b0;
            double_pending_next = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    led    = LED_NONE;
    pair   = 1'b0;
    freset = 1'b0;
    case (gest)
      G_SHORT: begin
        led  = LED_STOP;
        pair = (cfg.button_mode == MODE_PAIR_SHORT);
      end
      G_LONG:     led = LED_SLOW;
      G_LONG_REL: pair = (cfg.button_mode == MODE_PAIR_LONG);
      G_DBL_LONG: led = LED_FAST;
      G_DBL_LONG_REL: begin
        if (!cfg.local_reset_disable) begin
          freset = 1'b1;
          led    = LED_STOP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      was_long        <= 1'b0;
      double_pending  <= 1'b0;
      timer_remaining <= '0;
    end else if (step) begin
      armed           <= armed_next;
      was_long        <= was_long_next;
      double_pending  <= double_pending_next;
      timer_remaining <= timer_remaining_next;
    end
  end

  assign res.gesture       = gest;
  assign res.led_command   = led;
  assign res.send_pairing  = pair;
  assign res.factory_reset = freset;
  assign res.stay_awake_ms = awake;

endmodule

`default_nettype wire

// File: src/button_gesture_classifier.sv
// Top level of the button gesture classifier: input stage, core, result stage.
// Depends on bgc_pkg, bgc_if, bgc_cfg and bgc_core.
//
// One button item in, exactly one result out, one item per clock sustained
// while no result is stalled. An item is captured in an input register at
// its accepting edge, classified against the flag and countdown state while
// it is held there and written to a result register once that register is
// empty or being taken. The result register frees itself whenever its
// transaction completes, so the input side keeps accepting while a result is
// being taken; only a stalled result with a full input stage holds ready low.
// Configuration writes are taken on any cycle and are meant to be issued
// while no item is in flight.
`default_nettype none

module button_gesture_classifier import bgc_pkg::*; #(
  parameter int TIMER_BITS = TimerBitsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  bgc_in_if.sink                   button,
  bgc_out_if.source                result,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t       cfg;
  result_t    res;
  logic       s1_valid;
  logic [1:0] s1_status;
  logic       s1_tick;
  logic       s1_go;

  bgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s1_go        = s1_valid && (!result.valid || result.ready);
  assign button.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (button.ready) begin
      s1_valid <= button.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (button.valid && button.ready) begin
      s1_status <= button.button_status;
      s1_tick   <= button.tick;
    end
  end

  bgc_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_go),
    .button_status (s1_status),
    .tick          (s1_tick),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result.gesture       <= res.gesture;
      result.led_command   <= res.led_command;
      result.send_pairing  <= res.send_pairing;
      result.factory_reset <= res.factory_reset;
      result.stay_awake_ms <= res.stay_awake_ms;
    end
  end

endmodule

`default_nettype wire

// File: src/bgc_checker.sv
// Port-level checks for the gesture classifier, bound to the top level.
// Depends on bgc_pkg.
`default_nettype none

module bgc_checker import bgc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        gesture,
  input wire logic [1:0]        led_command,
  input wire logic              send_pairing,
  input wire logic              factory_reset,
  input wire logic [AwakeW-1:0] stay_awake_ms
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gesture) && $stable(stay_awake_ms))
    else $error("result changed while stalled");

  a_none_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && gesture == G_NONE |->
      led_command == LED_NONE && !send_pairing && !factory_reset)
    else $error("side effect without gesture");

  a_freset: assert property (@(posedge clk) disable iff (rst)
    out_valid && factory_reset |-> gesture == G_DBL_LONG_REL && led_command == LED_STOP)
    else $error("factory reset on wrong gesture");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_pairing |-> gesture == G_SHORT || gesture == G_LONG_REL)
    else $error("pairing on wrong gesture");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .gesture       (result.gesture),
  .led_command   (result.led_command),
  .send_pairing  (result.send_pairing),
  .factory_reset (result.factory_reset),
  .stay_awake_ms (result.stay_awake_ms)
);

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for button_gesture_classifier: directed and random button traffic
// is checked, result by result, against a gesture predictor kept in the bench.
// Depends on bgc_pkg, bgc_if and the RTL top level.

module tb;
  import bgc_pkg::*;

  localparam logic [1:0] MODE_NO_PAIR = 2'd3;  // enabled but never pairs
  localparam int unsigned IdleLimit   = 2000;

  logic     clk;
  logic     rst;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  bgc_in_if  btn();
  bgc_out_if res();

  button_gesture_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .button    (btn),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of configuration and state
  logic [1:0]       mode;
  logic [TimeW-1:0] long_ms;
  logic [TimeW-1:0] dbl_ms;
  logic             reset_blocked;
  logic             armed;
  logic             was_long;
  logic             dbl_pending;
  logic [TimeW-1:0] countdown;

  result_t     due_results[$];
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_writes;
  int unsigned n_errors;
  int unsigned idle_cycles;
  int unsigned gesture_seen[6];
  bit          gaps_on;
  bit          stalls_on;
  int unsigned hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [AwakeW-1:0] load_countdown(input logic [TimeW-1:0] ms);
    countdown = ms;
    return {1'b0, ms} + AwakeW'(AwakeExtra);
  endfunction

  function automatic result_t classify_press(input status_t st, input logic tk);
    result_t r;
    r = '0;
    if (tk && countdown != 0) countdown = countdown - 1'b1;
    if (mode != MODE_OFF) begin
      if (st == ST_FALL) begin
        r.stay_awake_ms = load_countdown(long_ms);
        armed = 1'b1;
      end
      if (armed) begin
        if (st == ST_RISE) begin
          r.stay_awake_ms = load_countdown(dbl_ms);
          if (was_long && !dbl_pending) begin
            dbl_pending = 1'b1;
            was_long    = 1'b0;
            r.gesture   = G_LONG_REL;
          end else if (was_long) begin
            r.gesture = G_DBL_LONG_REL;
          end else begin
            r.gesture = G_SHORT;
          end
        end
        if (countdown == 0) begin
          if (st == ST_PRESSED) begin
            r.stay_awake_ms = load_countdown(long_ms);
            if (!was_long) begin
              was_long  = 1'b1;
              r.gesture = dbl_pending ? G_DBL_LONG : G_LONG;
            end
          end else if (st == ST_RELEASED) begin
            armed       = 1'b0;
            was_long    = 1'b0;
            dbl_pending = 1'b0;
          end
        end
      end
    end
    case (r.gesture)
      G_SHORT: begin
        r.led_command  = LED_STOP;
        r.send_pairing = (mode == MODE_PAIR_SHORT);
      end
      G_LONG:     r.led_command = LED_SLOW;
      G_LONG_REL: r.send_pairing = (mode == MODE_PAIR_LONG);
      G_DBL_LONG: r.led_command = LED_FAST;
      G_DBL_LONG_REL: begin
        if (!reset_blocked) begin
          r.led_command   = LED_STOP;
          r.factory_reset = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    if (n_errors <= 40)
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // valid stays high on return so back-to-back items need no extra assignment
  task automatic send_item(input status_t st, input logic tk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      btn.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    btn.valid         <= 1'b1;
    btn.button_status <= st;
    btn.tick          <= tk;
    do @(posedge clk); while (!btn.ready);
    due_results.push_back(classify_press(st, tk));
    n_items++;
  endtask

  // one well-formed press: edge down, hold, edge up, rest
  task automatic press_cycle(input int hold, input int rest, input bit steady);
    send_item(ST_FALL, steady || $urandom_range(0, 1));
    repeat (hold) send_item(ST_PRESSED, steady || $urandom_range(0, 1));
    send_item(ST_RISE, steady || $urandom_range(0, 1));
    repeat (rest) send_item(ST_RELEASED, steady || $urandom_range(0, 1));
  endtask

  task automatic wait_idle();
    btn.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    n_writes++;
  endtask

  task automatic set_config(input logic [1:0] md, input logic [TimeW-1:0] lt,
                            input logic [TimeW-1:0] dt, input logic dis);
    wait_idle();
    write_reg(REG_MODE, CfgDataW'(md));
    write_reg(REG_LONG_TIME, lt);
    write_reg(REG_DBL_TIME, dt);
    write_reg(REG_RST_DIS, CfgDataW'(dis));
    cfg_we        <= 1'b0;
    mode          = md;
    long_ms       = lt;
    dbl_ms        = dt;
    reset_blocked = dis;
  endtask

  // reset configuration: mode 0, every status must give an all-zero result
  task automatic test_disabled();
    for (int s = 0; s < 4; s++) send_item(status_t'(s), s[0]);
  endtask

  // short, long, long release, double long, double long release, then clear
  task automatic test_press_gestures();
    set_config(MODE_PAIR_SHORT, 16'd2, 16'd3, 1'b0);
    press_cycle(0, 0, 1'b1);
    press_cycle(3, 1, 1'b1);
    press_cycle(3, 4, 1'b1);
  endtask

  task automatic test_pairing_modes();
    set_config(MODE_PAIR_LONG, 16'd2, 16'd3, 1'b0);
    press_cycle(3, 1, 1'b1);
    set_config(MODE_NO_PAIR, 16'd2, 16'd3, 1'b1);
    press_cycle(0, 0, 1'b1);
    press_cycle(3, 4, 1'b1);
  endtask

  task automatic test_time_extremes();
    set_config(MODE_PAIR_LONG, 16'd0, 16'd0, 1'b0);
    press_cycle(1, 1, 1'b1);
    set_config(MODE_PAIR_SHORT, 16'hFFFF, 16'hFFFF, 1'b1);
    press_cycle(2, 1, 1'b1);
  endtask

  task automatic test_random_gestures();
    logic [1:0]       md;
    logic [TimeW-1:0] lt;
    logic [TimeW-1:0] dt;
    int unsigned      stop_at;
    for (int ph = 0; ph < 10; ph++) begin
      md = ($urandom_range(0, 5) == 0) ? MODE_OFF : 2'($urandom_range(1, 3));
      lt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      dt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      set_config(md, lt, dt, 1'($urandom_range(0, 1)));
      stop_at = n_items + 36;
      while (n_items < stop_at) begin
        if ($urandom_range(0, 6) == 0)
          send_item(status_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        else
          press_cycle($urandom_range(0, 14), $urandom_range(0, 10), 1'b0);
      end
    end
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_input_stall();
    set_config(MODE_PAIR_SHORT, 16'd3, 16'd4, 1'b0);
    hold_len = 40;
    repeat (4) press_cycle($urandom_range(2, 8), $urandom_range(0, 4), 1'b0);
  endtask

  task automatic test_no_idling();
    set_config(MODE_PAIR_LONG, 16'd3, 16'd3, 1'b0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (5) press_cycle($urandom_range(0, 8), $urandom_range(0, 6), 1'b0);
  endtask

  // result receiver: random stall bursts, or one long hold-off on request
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        res.ready <= 1'b0;
        repeat (hold_len - 1) @(posedge clk);
        hold_len = 0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res.valid && res.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = due_results.pop_front();
        if (res.gesture !== want.gesture)
          report_mismatch("gesture", res.gesture, want.gesture);
        if (res.led_command !== want.led_command)
          report_mismatch("led_command", res.led_command, want.led_command);
        if (res.send_pairing !== want.send_pairing)
          report_mismatch("send_pairing", res.send_pairing, want.send_pairing);
        if (res.factory_reset !== want.factory_reset)
          report_mismatch("factory_reset", res.factory_reset, want.factory_reset);
        if (res.stay_awake_ms !== want.stay_awake_ms)
          report_mismatch("stay_awake_ms", res.stay_awake_ms, want.stay_awake_ms);
        gesture_seen[want.gesture]++;
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (btn.valid && btn.ready) || (res.valid && res.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transaction for %0d cycles", IdleLimit);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_MODE;
    cfg_data          <= '0;
    btn.valid         <= 1'b0;
    btn.button_status <= ST_RELEASED;
    btn.tick          <= 1'b0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    hold_len      = 0;
    mode          = MODE_OFF;
    long_ms       = LongTimeReset;
    dbl_ms        = DblTimeReset;
    reset_blocked = 1'b0;
    armed         = 1'b0;
    was_long      = 1'b0;
    dbl_pending   = 1'b0;
    countdown     = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_disabled();
    test_press_gestures();
    test_pairing_modes();
    test_time_extremes();
    test_random_gestures();
    test_input_stall();
    test_no_idling();
    wait_idle();

    $display("summary: %0d button items, %0d results checked, %0d register writes",
             n_items, n_results, n_writes);
    $display("summary: short %0d, long %0d, long rel %0d, dbl long %0d, dbl long rel %0d",
             gesture_seen[G_SHORT], gesture_seen[G_LONG], gesture_seen[G_LONG_REL],
             gesture_seen[G_DBL_LONG], gesture_seen[G_DBL_LONG_REL]);
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
